// ----- hdl/slx_pkg.sv -----
// Shared types, character codes and event codes of the shell command lexer.
`default_nettype none

package slx_pkg;

   localparam int CHAR_W     = 8;
   localparam int KIND_W     = 2;
   localparam int OP_W       = 3;
   localparam int QUOTE_W    = 2;
   localparam int PEND_W     = 3;
   localparam int MAX_EVENTS = 4;
   localparam int SLOTS      = 6;
   localparam int CNT_W      = $clog2(MAX_EVENTS + 1);
   localparam int IDX_W      = $clog2(MAX_EVENTS);

   // Character codes.
   localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [CHAR_W-1:0] CH_PIPE   = 8'h7C;
   localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_AMP    = 8'h26;
   localparam logic [CHAR_W-1:0] CH_TWO    = 8'h32;
   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

   // Event kinds.
   localparam logic [KIND_W-1:0] KIND_BYTE     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WORD_END = 2'd1;
   localparam logic [KIND_W-1:0] KIND_OP       = 2'd2;
   localparam logic [KIND_W-1:0] KIND_LINE     = 2'd3;

   // Operator codes.
   localparam logic [OP_W-1:0] OP_PIPE       = 3'd0;
   localparam logic [OP_W-1:0] OP_OUT        = 3'd1;
   localparam logic [OP_W-1:0] OP_APPEND     = 3'd2;
   localparam logic [OP_W-1:0] OP_IN         = 3'd3;
   localparam logic [OP_W-1:0] OP_AMP_OUT    = 3'd4;
   localparam logic [OP_W-1:0] OP_ERR_OUT    = 3'd5;
   localparam logic [OP_W-1:0] OP_ERR_APPEND = 3'd6;

   // Quote modes.
   localparam logic [QUOTE_W-1:0] Q_NONE   = 2'd0;
   localparam logic [QUOTE_W-1:0] Q_SINGLE = 2'd1;
   localparam logic [QUOTE_W-1:0] Q_DOUBLE = 2'd2;
   localparam logic [QUOTE_W-1:0] Q_ESCAPE = 2'd3;

   // Lookahead codes.
   localparam logic [PEND_W-1:0] PEND_NONE   = 3'd0;
   localparam logic [PEND_W-1:0] PEND_GT     = 3'd1;
   localparam logic [PEND_W-1:0] PEND_AMP    = 3'd2;
   localparam logic [PEND_W-1:0] PEND_DIGIT  = 3'd3;
   localparam logic [PEND_W-1:0] PEND_TWO_GT = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] char_out;
      logic [OP_W-1:0]   op_code;
      logic              line_end;
      logic              run_last;
   } slx_event_type;

   typedef struct packed {
      logic [QUOTE_W-1:0] quote;
      logic [PEND_W-1:0]  pend_kind;
      logic [CHAR_W-1:0]  pend_byte;
      logic               word_open;
   } slx_state_type;

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic slx_event_type byte_event(input logic [CHAR_W-1:0] c);
      slx_event_type e;
      e          = '0;
      e.kind     = KIND_BYTE;
      e.char_out = c;
      return e;
   endfunction

   function automatic slx_event_type op_event(input logic [OP_W-1:0] op);
      slx_event_type e;
      e         = '0;
      e.kind    = KIND_OP;
      e.op_code = op;
      return e;
   endfunction

   function automatic slx_event_type end_event();
      slx_event_type e;
      e      = '0;
      e.kind = KIND_WORD_END;
      return e;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/slx_ifs.sv -----
// Request and response channel interfaces of the shell command lexer.
`default_nettype none

interface slx_req_if;
   logic                      valid;
   logic                      ready;
   logic [slx_pkg::CHAR_W-1:0] char_in;
   logic                      line_last;

   modport source (output valid, output char_in, output line_last, input ready);
   modport sink   (input valid, input char_in, input line_last, output ready);
endinterface

interface slx_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [slx_pkg::KIND_W-1:0] kind;
   logic [slx_pkg::CHAR_W-1:0] char_out;
   logic [slx_pkg::OP_W-1:0]   op_code;
   logic                       line_end;
   logic                       run_last;

   modport source (output valid, output kind, output char_out, output op_code,
                   output line_end, output run_last, input ready);
   modport sink   (input valid, input kind, input char_out, input op_code,
                   input line_end, input run_last, output ready);
endinterface

`default_nettype wire

// ----- hdl/slx_decode.sv -----
// Lexer step logic: turns one byte and the lexer state into events and the next state.
`default_nettype none

module slx_decode (
   input  logic [slx_pkg::CHAR_W-1:0]                       char_in,
   input  logic                                             line_last,
   input  slx_pkg::slx_state_type                           state,
   output slx_pkg::slx_state_type                           state_nx,
   output slx_pkg::slx_event_type [slx_pkg::MAX_EVENTS-1:0] events,
   output logic [slx_pkg::CNT_W-1:0]                        count
);
   import slx_pkg::*;

   slx_event_type [SLOTS-1:0] slot_evt;
   logic [SLOTS-1:0]          slot_vld;
   slx_state_type             nx;
   logic                      to_unquoted;
   logic                      is_gt;
   logic [CNT_W-1:0]          cnt;
   logic [IDX_W-1:0]          last_idx;

   always_comb begin
      slot_evt    = '0;
      slot_vld    = '0;
      nx          = state;
      to_unquoted = 1'b0;
      is_gt       = (char_in == CH_GT);

      case (state.quote)
         Q_SINGLE: begin
            if (char_in == CH_SQUOTE) begin
               nx.quote = Q_NONE;
            end else begin
               slot_vld[1]  = 1'b1;
               slot_evt[1]  = byte_event(char_in);
               nx.word_open = 1'b1;
            end
         end
         Q_DOUBLE: begin
            if (char_in == CH_DQUOTE) begin
               nx.quote = Q_NONE;
            end else if (char_in == CH_BSLASH && !line_last) begin
               nx.quote = Q_ESCAPE;
            end else begin
               slot_vld[1]  = 1'b1;
               slot_evt[1]  = byte_event(char_in);
               nx.word_open = 1'b1;
            end
         end
         Q_ESCAPE: begin
            slot_vld[1]  = 1'b1;
            slot_evt[1]  = byte_event(char_in);
            nx.word_open = 1'b1;
            nx.quote     = Q_DOUBLE;
         end
         default: begin
            nx.pend_kind = PEND_NONE;
            nx.pend_byte = '0;
            to_unquoted  = 1'b1;
            // Resolve the lookahead left by the previous byte.
            case (state.pend_kind)
               PEND_GT: begin
                  slot_vld[0] = 1'b1;
                  slot_evt[0] = op_event(is_gt ? OP_APPEND : OP_OUT);
                  to_unquoted = !is_gt;
               end
               PEND_AMP: begin
                  slot_vld[0] = 1'b1;
                  if (is_gt) begin
                     slot_evt[0] = op_event(OP_AMP_OUT);
                     to_unquoted = 1'b0;
                  end else begin
                     slot_evt[0]  = byte_event(CH_AMP);
                     nx.word_open = 1'b1;
                  end
               end
               PEND_DIGIT: begin
                  if (is_gt) begin
                     to_unquoted  = 1'b0;
                     slot_vld[0]  = state.word_open;
                     slot_evt[0]  = end_event();
                     nx.word_open = 1'b0;
                     if (state.pend_byte == CH_TWO) begin
                        nx.pend_kind = PEND_TWO_GT;
                     end else begin
                        slot_vld[1] = 1'b1;
                        slot_evt[1] = op_event(OP_ERR_OUT);
                     end
                  end else begin
                     slot_vld[0]  = 1'b1;
                     slot_evt[0]  = byte_event(state.pend_byte);
                     nx.word_open = 1'b1;
                  end
               end
               PEND_TWO_GT: begin
                  slot_vld[0] = 1'b1;
                  slot_evt[0] = op_event(is_gt ? OP_ERR_APPEND : OP_ERR_OUT);
                  to_unquoted = !is_gt;
               end
               default: ;
            endcase

            if (to_unquoted) begin
               if (char_in == CH_SQUOTE) begin
                  nx.quote = Q_SINGLE;
               end else if (char_in == CH_DQUOTE) begin
                  nx.quote = Q_DOUBLE;
               end else if (char_in == CH_PIPE || char_in == CH_LT) begin
                  slot_vld[1]  = nx.word_open;
                  slot_evt[1]  = end_event();
                  nx.word_open = 1'b0;
                  slot_vld[2]  = 1'b1;
                  slot_evt[2]  = op_event((char_in == CH_PIPE) ? OP_PIPE : OP_IN);
               end else if (is_gt || char_in == CH_AMP) begin
                  slot_vld[1]  = nx.word_open;
                  slot_evt[1]  = end_event();
                  nx.word_open = 1'b0;
                  nx.pend_kind = is_gt ? PEND_GT : PEND_AMP;
               end else if (is_digit(char_in)) begin
                  nx.pend_kind = PEND_DIGIT;
                  nx.pend_byte = char_in;
               end else if (is_space(char_in)) begin
                  slot_vld[1]  = nx.word_open;
                  slot_evt[1]  = end_event();
                  nx.word_open = 1'b0;
               end else begin
                  slot_vld[1]  = 1'b1;
                  slot_evt[1]  = byte_event(char_in);
                  nx.word_open = 1'b1;
               end
            end
         end
      endcase

      // At line end the lookahead resolves as if nothing followed and the open word closes.
      if (line_last) begin
         case (nx.pend_kind)
            PEND_GT: begin
               slot_vld[3] = 1'b1;
               slot_evt[3] = op_event(OP_OUT);
            end
            PEND_AMP: begin
               slot_vld[3]  = 1'b1;
               slot_evt[3]  = byte_event(CH_AMP);
               nx.word_open = 1'b1;
            end
            PEND_DIGIT: begin
               slot_vld[3]  = 1'b1;
               slot_evt[3]  = byte_event(nx.pend_byte);
               nx.word_open = 1'b1;
            end
            PEND_TWO_GT: begin
               slot_vld[3] = 1'b1;
               slot_evt[3] = op_event(OP_ERR_OUT);
            end
            default: ;
         endcase
         slot_vld[4]  = nx.word_open;
         slot_evt[4]  = end_event();
         slot_vld[5]  = ~|slot_vld[4:0];
         slot_evt[5]  = '0;
         slot_evt[5].kind = KIND_LINE;
         nx           = '0;
      end
   end

   // Pack the valid slots into the event list and flag its last entry.
   always_comb begin
      events   = '0;
      cnt      = '0;
      last_idx = '0;
      for (int s = 0; s < SLOTS; s++) begin
         if (slot_vld[s] && cnt < CNT_W'(MAX_EVENTS)) begin
            events[cnt[IDX_W-1:0]] = slot_evt[s];
            cnt                    = cnt + CNT_W'(1);
         end
      end
      if (cnt != '0) begin
         last_idx                   = cnt[IDX_W-1:0] - IDX_W'(1);
         events[last_idx].run_last  = 1'b1;
         events[last_idx].line_end  = line_last;
      end
   end

   assign count    = cnt;
   assign state_nx = nx;

endmodule

`default_nettype wire

// ----- hdl/shell_command_lexer_top.sv -----
// Top level of the shell command lexer: lexer state, event list register and handshakes.
`default_nettype none

// Takes one command-line byte per request and returns its token events (word bytes,
// word ends, operators, or a bare line-end marker) one per response. A byte is
// decoded in the cycle it is accepted and its up to four events are written into a
// small event register that drains one event per cycle while the consumer is ready.
// A new byte is accepted in the same cycle as the last pending event leaves, so bytes
// giving at most one event stream at one per cycle under that condition; others hold
// the next byte until their events have left. After reset the block is ready at once.

module shell_command_lexer_top (
   input logic        clock,
   input logic        reset,
   slx_req_if.sink    req_ch,
   slx_rsp_if.source  rsp_ch
);
   import slx_pkg::*;

   slx_state_type                    state_ff;
   slx_state_type                    state_in;
   slx_state_type                    state_dec;
   slx_event_type [MAX_EVENTS-1:0]   dec_events;
   logic [CNT_W-1:0]                 dec_count;
   slx_event_type [MAX_EVENTS-1:0]   evt_ff;
   slx_event_type [MAX_EVENTS-1:0]   evt_in;
   logic [CNT_W-1:0]                 cnt_ff;
   logic [CNT_W-1:0]                 cnt_in;
   logic                             take_req;
   logic                             pop_rsp;

   slx_decode u_decode (
      .char_in   (req_ch.char_in),
      .line_last (req_ch.line_last),
      .state     (state_ff),
      .state_nx  (state_dec),
      .events    (dec_events),
      .count     (dec_count)
   );

   assign pop_rsp      = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = (cnt_ff == '0) || (cnt_ff == CNT_W'(1) && rsp_ch.ready);
   assign take_req     = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in = state_ff;
      evt_in   = evt_ff;
      cnt_in   = cnt_ff;
      if (take_req) begin
         state_in = state_dec;
         evt_in   = dec_events;
         cnt_in   = dec_count;
      end else if (pop_rsp) begin
         for (int i = 0; i < MAX_EVENTS - 1; i++) begin
            evt_in[i] = evt_ff[i + 1];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      evt_ff <= evt_in;
   end

   assign rsp_ch.valid    = (cnt_ff != '0);
   assign rsp_ch.kind     = evt_ff[0].kind;
   assign rsp_ch.char_out = evt_ff[0].char_out;
   assign rsp_ch.op_code  = evt_ff[0].op_code;
   assign rsp_ch.line_end = evt_ff[0].line_end;
   assign rsp_ch.run_last = evt_ff[0].run_last;

endmodule

`default_nettype wire

// ----- hdl/slx_checker.sv -----
// Port-level checks of the shell command lexer and their binding to the top level.
`default_nettype none

module slx_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [slx_pkg::KIND_W-1:0] rsp_kind,
   input logic [slx_pkg::CHAR_W-1:0] rsp_char_out,
   input logic [slx_pkg::OP_W-1:0]   rsp_op_code,
   input logic                       rsp_line_end,
   input logic                       rsp_run_last
);
   import slx_pkg::*;

   // A stalled response keeps its event.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_char_out)
         && $stable(rsp_op_code) && $stable(rsp_line_end) && $stable(rsp_run_last))
      else $error("stalled response changed");

   // A request cannot be taken while an event is held back by the consumer.
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted while response stalled");

   // The final event of a line is always the last event of its byte.
   a_line_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_end |-> rsp_run_last)
      else $error("line end without run last");

   // A bare line-end marker carries nothing else and closes both the byte and the line.
   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_LINE |-> rsp_char_out == '0 && rsp_op_code == '0
         && rsp_line_end && rsp_run_last)
      else $error("malformed line-end marker");

   // Unused fields of an event are zero; this is checked only while a request is also valid.
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && req_valid |-> (rsp_kind == KIND_BYTE || rsp_char_out == '0)
         && (rsp_kind == KIND_OP || rsp_op_code == '0))
      else $error("unused event field not zero");

endmodule

bind shell_command_lexer_top slx_checker u_slx_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_kind     (rsp_ch.kind),
   .rsp_char_out (rsp_ch.char_out),
   .rsp_op_code  (rsp_ch.op_code),
   .rsp_line_end (rsp_ch.line_end),
   .rsp_run_last (rsp_ch.run_last)
);

`default_nettype wire
